// ----- rtl/ridc_pkg.sv -----
// Shared types and constants for the route id cache table.
package ridc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_FIND_ID  = 2'd1;
    localparam logic [1:0] ACT_FIND_DST = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_NEW     = 3'd2;
    localparam logic [2:0] ST_UPDATED = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] src_addr;
        logic [47:0] dst_addr;
        logic [47:0] prev_hop_addr;
        logic [47:0] nexthop_addr;
        logic [31:0] route_ident;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [31:0] hit_route_ident;
        logic [47:0] hit_src;
        logic [47:0] hit_dst;
        logic [47:0] hit_prev_hop;
        logic [47:0] hit_next_hop;
    } result_t;

    // item travelling down the cell row
    typedef struct packed {
        logic    vld;
        logic    found;
        cmd_t    cmd;
        result_t rsp;
    } token_t;

endpackage

// ----- rtl/ridc_cell.sv -----
// One table entry with its compare logic and a token stage toward the next cell.
module ridc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ridc_pkg::IDX_W-1:0]    cell_idx,
    input  logic [ridc_pkg::CNT_W-1:0]    count,
    input  ridc_pkg::token_t              tok_in,
    output ridc_pkg::token_t              tok_out
);
    import ridc_pkg::*;

    logic [47:0] e_src_reg;
    logic [47:0] e_dst_reg;
    logic [47:0] e_prev_reg;
    logic [47:0] e_next_reg;
    logic [31:0] e_rid_reg;

    logic    vld_reg;
    logic    found_reg;
    cmd_t    cmd_reg;
    result_t rsp_reg;
    token_t  tok_next;

    logic live;
    logic used;
    logic match_id;
    logic match_dst;
    logic hit;
    logic new_slot;
    logic is_ins;

    always_comb
    begin
        live      = tok_in.vld && !tok_in.found;
        used      = CNT_W'(cell_idx) < count;
        is_ins    = tok_in.cmd.action == ACT_INSERT;
        match_id  = used && (e_src_reg == tok_in.cmd.src_addr)
                    && (e_rid_reg == tok_in.cmd.route_ident);
        match_dst = used && (e_src_reg == tok_in.cmd.src_addr)
                    && (e_dst_reg == tok_in.cmd.dst_addr);
        hit       = 1'b0;
        if (live)
        begin
            unique case (tok_in.cmd.action)
                ACT_INSERT, ACT_FIND_ID: hit = match_id;
                ACT_FIND_DST:            hit = match_dst;
                default:                 hit = 1'b0;
            endcase
        end
        // first free slot sits right after the last used entry
        new_slot  = live && is_ins && (CNT_W'(cell_idx) == count);

        tok_next       = tok_in;
        tok_next.found = tok_in.found || hit || new_slot;
        if (hit || new_slot)
        begin
            tok_next.rsp.entry_index = 4'(cell_idx);
            if (is_ins)
            begin
                tok_next.rsp.status          = new_slot ? ST_NEW : ST_UPDATED;
                tok_next.rsp.hit_route_ident = tok_in.cmd.route_ident;
                tok_next.rsp.hit_src         = tok_in.cmd.src_addr;
                tok_next.rsp.hit_dst         = tok_in.cmd.dst_addr;
                tok_next.rsp.hit_prev_hop    = tok_in.cmd.prev_hop_addr;
                tok_next.rsp.hit_next_hop    = tok_in.cmd.nexthop_addr;
            end
            else
            begin
                tok_next.rsp.status          = ST_HIT;
                tok_next.rsp.hit_route_ident = e_rid_reg;
                tok_next.rsp.hit_src         = e_src_reg;
                tok_next.rsp.hit_dst         = e_dst_reg;
                tok_next.rsp.hit_prev_hop    = e_prev_reg;
                tok_next.rsp.hit_next_hop    = e_next_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((hit && is_ins) || new_slot)
        begin
            e_dst_reg  <= tok_in.cmd.dst_addr;
            e_prev_reg <= tok_in.cmd.prev_hop_addr;
            e_next_reg <= tok_in.cmd.nexthop_addr;
        end
        if (new_slot)
        begin
            e_src_reg <= tok_in.cmd.src_addr;
            e_rid_reg <= tok_in.cmd.route_ident;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tok_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= tok_next.found;
        cmd_reg   <= tok_next.cmd;
        rsp_reg   <= tok_next.rsp;
    end

    assign tok_out = {vld_reg, found_reg, cmd_reg, rsp_reg};

endmodule

// ----- rtl/route_id_cache_table_top.sv -----
// Route id cache table: a row of entry cells walked by each item in index order.
// Each item passes the cell stages in index order, then the done and result registers.
// A new item is accepted only once the previous one has finished; the item visits one cell per cycle.
// busy falls in the done cycle, so the next item may be accepted while done is high.
// Reset clears the entry count and the valid bits of the cell stages; entry contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module route_id_cache_table_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ridc_pkg::cmd_t    cmd,
    output logic              done,
    output ridc_pkg::result_t result
);
    import ridc_pkg::*;

    token_t tok [TABLE_DEPTH+1];

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    result_t          res_reg;
    result_t          res_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    token_t           last;

    assign accept = start && !busy_reg;

    assign tok[0] = {accept, 1'b0, cmd, result_t'('0)};

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ridc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .count    (count_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign last = tok[TABLE_DEPTH];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = last.vld;
        count_next = count_reg;
        res_next   = last.rsp;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (last.vld)
        begin
            busy_next = 1'b0;
            if (!last.found)
            begin
                res_next        = '0;
                res_next.status = (last.cmd.action == ACT_INSERT) ? ST_FULL : ST_MISS;
            end
            else if (last.rsp.status == ST_NEW)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not set after accept");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above depth");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status == ST_NEW) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("new entry without count step");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (res_reg.status == ST_MISS || res_reg.status == ST_FULL))
        |-> (res_reg.entry_index == '0 && res_reg.hit_src == '0))
        else $error("miss result carries entry data");

endmodule
